// ----- rtl/sts_pkg.sv -----
// Shared constants, coefficient table and Q30 multiply helper for the sine series unit
package sts_pkg;

  localparam int ANGLE_W       = 16;
  localparam int RESULT_W      = 16;
  localparam int TC_W          = 3;
  localparam int Q_BITS        = 30;
  localparam int P_W           = 59;   // Q30 magnitude, capped at 2^58
  localparam int SQ_W          = 31;   // |x|^2 as an integer, at most 2^30
  localparam int CM_W          = 31;
  localparam int SUM_W         = 62;   // signed sum of up to six capped terms
  localparam int HALF_W        = 32;
  localparam int PP_W          = 64;
  localparam int MAX_TERMS_DEF = 6;
  localparam int FRAC_BITS_DEF = 13;

  localparam logic [TC_W-1:0] TERM_COUNT_RST = 3'd6;
  localparam logic [P_W-1:0]  MAG_CAP        = {1'b1, 58'd0};

  localparam logic [RESULT_W-1:0] RESULT_MAX = 16'h7fff;
  localparam logic [RESULT_W-1:0] RESULT_MIN = 16'h8000;

  // |1/(2i+1)!| in Q30; the sign alternates with the term index
  localparam logic [CM_W-1:0] RECIP_MAG [6] = '{
    31'd1073741824, 31'd178956971, 31'd8947849, 31'd213044, 31'd2959, 31'd27
  };

  // Sum four 32x32 partial products, drop 30 fraction bits, clamp at 2^58
  function automatic logic [P_W-1:0] mulq_sat(input logic [PP_W-1:0] pp00,
                                              input logic [PP_W-1:0] pp01,
                                              input logic [PP_W-1:0] pp10,
                                              input logic [PP_W-1:0] pp11);
    logic [2*PP_W-1:0]        prod;
    logic [2*PP_W-Q_BITS-1:0] shifted;
    prod = {64'd0, pp00}
         + ({64'd0, pp01} << HALF_W)
         + ({64'd0, pp10} << HALF_W)
         + {pp11, 64'd0};
    shifted = prod[2*PP_W-1:Q_BITS];
    if (shifted > (2*PP_W-Q_BITS)'(MAG_CAP)) begin
      return MAG_CAP;
    end
    return shifted[P_W-1:0];
  endfunction

endpackage

// ----- rtl/sts_front.sv -----
// Front end: angle magnitude and sign, |x|^2, first odd power in Q30
module sts_front #(
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF,
  parameter int X2W       = sts_pkg::SQ_W
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [sts_pkg::ANGLE_W-1:0] angle_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sts_pkg::P_W-1:0]            p_o,
  output logic [X2W-1:0]                     x2_o,
  output logic                               neg_o
);

  localparam int K = sts_pkg::Q_BITS - 2 * FRAC_BITS;

  logic                          v0_q, v1_q;
  logic                          en0, en1;
  logic [sts_pkg::ANGLE_W-1:0]   ax_d, ax0_q, ax1_q;
  logic                          neg0_q, neg1_q;
  logic [2*sts_pkg::ANGLE_W-1:0] sq_full;
  logic [sts_pkg::SQ_W-1:0]      sq_q;

  assign en1        = !v1_q || out_ready_i;
  assign en0        = !v0_q || en1;
  assign in_ready_o = en0;

  // two's complement magnitude; -32768 maps to 32768, which fits unsigned
  assign ax_d    = angle_i[sts_pkg::ANGLE_W-1] ? (~angle_i + 1'b1) : angle_i;
  assign sq_full = ax0_q * ax0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      ax0_q  <= ax_d;
      neg0_q <= angle_i[sts_pkg::ANGLE_W-1];
    end
    if (en1) begin
      ax1_q  <= ax0_q;
      neg1_q <= neg0_q;
      sq_q   <= sq_full[sts_pkg::SQ_W-1:0];
    end
  end

  assign p_o         = sts_pkg::P_W'(ax1_q) << (sts_pkg::Q_BITS - FRAC_BITS);
  assign neg_o       = neg1_q;
  assign out_valid_o = v1_q;

  if (K >= 0) begin : g_x2_up
    assign x2_o = X2W'(sq_q) << K;
  end else begin : g_x2_down
    assign x2_o = X2W'(sq_q >> (-K));
  end

endmodule

// ----- rtl/sts_term.sv -----
// One series term: partial products, then term and next odd power with clamping
module sts_term #(
  parameter int IDX       = 0,
  parameter int X2W       = sts_pkg::SQ_W,
  parameter bit HAS_POWER = 1'b1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [sts_pkg::TC_W-1:0]         term_count_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sts_pkg::P_W-1:0]          p_i,
  input  logic [X2W-1:0]                   x2_i,
  input  logic                             neg_i,
  input  logic signed [sts_pkg::SUM_W-1:0] sum_i,
  input  logic [sts_pkg::P_W-1:0]          term_i,
  input  logic                             term_neg_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sts_pkg::P_W-1:0]          p_o,
  output logic [X2W-1:0]                   x2_o,
  output logic                             neg_o,
  output logic signed [sts_pkg::SUM_W-1:0] sum_o,
  output logic [sts_pkg::P_W-1:0]          term_o,
  output logic                             term_neg_o
);

  localparam logic [sts_pkg::TC_W-1:0] IDX_TC   = sts_pkg::TC_W'(IDX);
  localparam logic [sts_pkg::CM_W-1:0] CM       = sts_pkg::RECIP_MAG[IDX_TC];
  localparam logic                     COEF_NEG = IDX_TC[0];

  logic                             v0_q, v1_q;
  logic                             en0, en1;
  logic [sts_pkg::PP_W-1:0]         a_ext;
  logic [sts_pkg::HALF_W-1:0]       al, ah;
  logic [sts_pkg::PP_W-1:0]         tm0_d, tm1_d, tm0_q, tm1_q;
  logic signed [sts_pkg::SUM_W-1:0] term_ext, sum_d, sum0_q, sum1_q;
  logic [X2W-1:0]                   x20_q, x21_q;
  logic                             neg0_q, neg1_q;
  logic                             include_term;
  logic [sts_pkg::P_W-1:0]          term_d, term_q;

  assign en1        = !v1_q || out_ready_i;
  assign en0        = !v0_q || en1;
  assign in_ready_o = en0;

  assign a_ext = sts_pkg::PP_W'(p_i);
  assign al    = a_ext[sts_pkg::HALF_W-1:0];
  assign ah    = a_ext[sts_pkg::PP_W-1:sts_pkg::HALF_W];
  assign tm0_d = al * CM;
  assign tm1_d = ah * CM;

  // previous term is folded into the running sum here
  assign term_ext = signed'(sts_pkg::SUM_W'(term_i));
  assign sum_d    = term_neg_i ? (sum_i - term_ext) : (sum_i + term_ext);

  // terms at or beyond the configured count contribute nothing
  assign include_term = IDX_TC < term_count_i;
  assign term_d = include_term ? sts_pkg::mulq_sat(tm0_q, '0, tm1_q, '0) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      tm0_q  <= tm0_d;
      tm1_q  <= tm1_d;
      sum0_q <= sum_d;
      x20_q  <= x2_i;
      neg0_q <= neg_i;
    end
    if (en1) begin
      term_q     <= term_d;
      term_neg_o <= neg0_q ^ COEF_NEG;
      sum1_q     <= sum0_q;
      x21_q      <= x20_q;
      neg1_q     <= neg0_q;
    end
  end

  if (HAS_POWER) begin : g_power
    logic [sts_pkg::PP_W-1:0]   b_ext;
    logic [sts_pkg::HALF_W-1:0] bl, bh;
    logic [sts_pkg::PP_W-1:0]   pp_q [4];
    logic [sts_pkg::P_W-1:0]    p_q;

    assign b_ext = sts_pkg::PP_W'(x2_i);
    assign bl    = b_ext[sts_pkg::HALF_W-1:0];
    assign bh    = b_ext[sts_pkg::PP_W-1:sts_pkg::HALF_W];

    always_ff @(posedge clk_i) begin
      if (en0) begin
        pp_q[0] <= al * bl;
        pp_q[1] <= al * bh;
        pp_q[2] <= ah * bl;
        pp_q[3] <= ah * bh;
      end
      if (en1) begin
        p_q <= sts_pkg::mulq_sat(pp_q[0], pp_q[1], pp_q[2], pp_q[3]);
      end
    end

    assign p_o = p_q;
  end else begin : g_no_power
    assign p_o = '0;
  end

  assign out_valid_o = v1_q;
  assign x2_o        = x21_q;
  assign neg_o       = neg1_q;
  assign sum_o       = sum1_q;
  assign term_o      = term_q;

endmodule

// ----- rtl/sts_round.sv -----
// Back end: last accumulation, round half up to the output format, saturate
module sts_round #(
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sts_pkg::SUM_W-1:0]    sum_i,
  input  logic [sts_pkg::P_W-1:0]             term_i,
  input  logic                                term_neg_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sts_pkg::RESULT_W-1:0] sine_value_o,
  output logic                                saturated_o
);

  localparam int SH  = sts_pkg::Q_BITS - FRAC_BITS;
  localparam int RW  = 64;
  localparam logic signed [RW-1:0] HALF  = RW'(1) << (SH - 1);
  localparam logic signed [RW-1:0] R_MAX = RW'(32767);
  localparam logic signed [RW-1:0] R_MIN = -RW'(32768);

  logic                                v0_q, v1_q;
  logic                                en0, en1;
  logic signed [sts_pkg::SUM_W-1:0]    term_ext, acc_d, acc_q;
  logic signed [RW-1:0]                biased, shifted;
  logic signed [sts_pkg::RESULT_W-1:0] value_d;
  logic                                sat_d;

  assign en1        = !v1_q || out_ready_i;
  assign en0        = !v0_q || en1;
  assign in_ready_o = en0;

  assign term_ext = signed'(sts_pkg::SUM_W'(term_i));
  assign acc_d    = term_neg_i ? (sum_i - term_ext) : (sum_i + term_ext);

  always_comb begin
    biased  = RW'(acc_q) + HALF;
    shifted = biased >>> SH;
    sat_d   = 1'b0;
    value_d = shifted[sts_pkg::RESULT_W-1:0];
    if (shifted > R_MAX) begin
      value_d = sts_pkg::RESULT_MAX;
      sat_d   = 1'b1;
    end else if (shifted < R_MIN) begin
      value_d = sts_pkg::RESULT_MIN;
      sat_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) acc_q <= acc_d;
    if (en1) begin
      sine_value_o <= value_d;
      saturated_o  <= sat_d;
    end
  end

  assign out_valid_o = v1_q;

endmodule

// ----- rtl/sine_taylor_series_unit.sv -----
// Sine series unit top: term-count register and the pipeline of series terms
//
// Input channel: in_valid_i / in_ready_o with angle_i, signed, FRAC_BITS
// fraction bits (Q3.13 by default). Output channel: out_valid_o / out_ready_i
// with sine_value_o in the same format and saturated_o, set when the sum was
// clipped to the 16-bit range. One result per angle, in order.
// term_count is written through cfg_we_i / cfg_wdata_i, by the user only while
// no item is in flight; the block does not enforce this. 0 gives a result of
// 0, values above MAX_TERMS act as MAX_TERMS. Pipeline stages: two front
// stages for magnitude and square, two per term for the split 32x32 partial
// products and their recombination, two for the final sum and rounding.
// Throughput: one item per cycle. Each stage has its own valid bit and takes
// new data whenever it is empty or its successor moves, so bubbles close up.
// When the receiver stalls, results back up stage by stage; in_ready_o drops
// only once every stage holds an item. Nothing is dropped or repeated.
// Reset clears all valid bits and sets term_count to 6; data registers are
// not reset.
module sine_taylor_series_unit #(
  parameter int MAX_TERMS = sts_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sts_pkg::TC_W-1:0]            cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sts_pkg::ANGLE_W-1:0]  angle_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sts_pkg::RESULT_W-1:0] sine_value_o,
  output logic                                saturated_o
);

  localparam int K   = sts_pkg::Q_BITS - 2 * FRAC_BITS;
  localparam int X2W = (K > 0) ? sts_pkg::SQ_W + K : sts_pkg::SQ_W;

  logic [sts_pkg::TC_W-1:0]         term_count_q;

  logic                             st_valid [MAX_TERMS+1];
  logic                             st_ready [MAX_TERMS+1];
  logic signed [sts_pkg::SUM_W-1:0] sum_w    [MAX_TERMS+1];
  logic [sts_pkg::P_W-1:0]          term_w   [MAX_TERMS+1];
  logic                             tneg_w   [MAX_TERMS+1];
  logic [sts_pkg::P_W-1:0]          p_w      [MAX_TERMS];
  logic [X2W-1:0]                   x2_w     [MAX_TERMS];
  logic                             neg_w    [MAX_TERMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= sts_pkg::TERM_COUNT_RST;
    end else if (cfg_we_i) begin
      term_count_q <= cfg_wdata_i;
    end
  end

  sts_front #(
    .FRAC_BITS (FRAC_BITS),
    .X2W       (X2W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .angle_i     (angle_i),
    .out_valid_o (st_valid[0]),
    .out_ready_i (st_ready[0]),
    .p_o         (p_w[0]),
    .x2_o        (x2_w[0]),
    .neg_o       (neg_w[0])
  );

  assign sum_w[0]  = '0;
  assign term_w[0] = '0;
  assign tneg_w[0] = 1'b0;

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_term
    if (i < MAX_TERMS - 1) begin : g_mid
      sts_term #(
        .IDX       (i),
        .X2W       (X2W),
        .HAS_POWER (1'b1)
      ) u_term (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .term_count_i (term_count_q),
        .in_valid_i   (st_valid[i]),
        .in_ready_o   (st_ready[i]),
        .p_i          (p_w[i]),
        .x2_i         (x2_w[i]),
        .neg_i        (neg_w[i]),
        .sum_i        (sum_w[i]),
        .term_i       (term_w[i]),
        .term_neg_i   (tneg_w[i]),
        .out_valid_o  (st_valid[i+1]),
        .out_ready_i  (st_ready[i+1]),
        .p_o          (p_w[i+1]),
        .x2_o         (x2_w[i+1]),
        .neg_o        (neg_w[i+1]),
        .sum_o        (sum_w[i+1]),
        .term_o       (term_w[i+1]),
        .term_neg_o   (tneg_w[i+1])
      );
    end else begin : g_last
      sts_term #(
        .IDX       (i),
        .X2W       (X2W),
        .HAS_POWER (1'b0)
      ) u_term (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .term_count_i (term_count_q),
        .in_valid_i   (st_valid[i]),
        .in_ready_o   (st_ready[i]),
        .p_i          (p_w[i]),
        .x2_i         (x2_w[i]),
        .neg_i        (neg_w[i]),
        .sum_i        (sum_w[i]),
        .term_i       (term_w[i]),
        .term_neg_i   (tneg_w[i]),
        .out_valid_o  (st_valid[i+1]),
        .out_ready_i  (st_ready[i+1]),
        .p_o          (),
        .x2_o         (),
        .neg_o        (),
        .sum_o        (sum_w[i+1]),
        .term_o       (term_w[i+1]),
        .term_neg_o   (tneg_w[i+1])
      );
    end
  end

  sts_round #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (st_valid[MAX_TERMS]),
    .in_ready_o   (st_ready[MAX_TERMS]),
    .sum_i        (sum_w[MAX_TERMS]),
    .term_i       (term_w[MAX_TERMS]),
    .term_neg_i   (tneg_w[MAX_TERMS]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sine_value_o (sine_value_o),
    .saturated_o  (saturated_o)
  );

`ifndef ASSERT_OFF
  // a clipped result sits at one of the range ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (sine_value_o == sts_pkg::RESULT_MAX || sine_value_o == sts_pkg::RESULT_MIN))
    else $error("saturated result not at a range end");

  // input side backs up only when every stage is full and the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while pipeline has room");

  // odd powers never exceed the magnitude cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid[MAX_TERMS-1] |-> p_w[MAX_TERMS-1] <= sts_pkg::MAG_CAP)
    else $error("odd power above cap");
`endif

endmodule

// ----- test/sts_checker.sv -----
// Sine series unit scoreboard: shadows term_count, predicts each angle and checks each result
`timescale 1ns / 100ps

module sts_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sts_pkg::TC_W-1:0]            cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [sts_pkg::ANGLE_W-1:0]  angle_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [sts_pkg::RESULT_W-1:0] sine_value_i,
  input  logic                                saturated_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  checked_o,
  output int                                  clipped_o
);

  localparam int          N_TERMS    = sts_pkg::MAX_TERMS_DEF;
  localparam int          FRAC       = sts_pkg::FRAC_BITS_DEF;
  localparam int          QF         = 30;
  localparam int          DROP       = QF - FRAC;
  localparam logic [63:0] POW_CAP    = 64'd1 << 58;
  localparam longint      HALF_LSB   = longint'(1) << (DROP - 1);
  localparam int          MAX_REPORT = 20;

  // magnitudes of 1/1!, 1/3!, ... 1/11! in Q30; odd terms are subtracted
  localparam logic [63:0] INV_FACT [6] = '{
    64'd1073741824, 64'd178956971, 64'd8947849, 64'd213044, 64'd2959, 64'd27
  };

  typedef struct packed {
    logic signed [sts_pkg::ANGLE_W-1:0]  angle;
    logic signed [sts_pkg::RESULT_W-1:0] sine;
    logic                                sat;
  } sine_expect_t;

  sine_expect_t              sine_expect_q[$];
  logic [sts_pkg::TC_W-1:0]  term_count_q;
  int                        reports;

  // Q30 product of two magnitudes, truncated, clamped at 2^58
  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    logic [127:0] scaled;
    prod   = {64'd0, a} * {64'd0, b};
    scaled = prod >> QF;
    if (scaled > {64'd0, POW_CAP}) return POW_CAP;
    return scaled[63:0];
  endfunction

  function automatic sine_expect_t predict_sine(input logic signed [sts_pkg::ANGLE_W-1:0] x,
                                                input logic [sts_pkg::TC_W-1:0] tc);
    logic                neg;
    logic [16:0]         mag;
    logic [63:0]         x_sq;
    logic [63:0]         pw;
    logic [63:0]         term;
    logic signed [63:0]  acc;
    logic signed [63:0]  rounded;
    int                  n;
    sine_expect_t        res;
    neg  = x[sts_pkg::ANGLE_W-1];
    mag  = neg ? (17'h10000 - {1'b0, x[15:0]}) : {1'b0, x[15:0]};
    x_sq = (64'(mag) * 64'(mag)) << (QF - 2 * FRAC);
    pw   = 64'(mag) << DROP;
    if (pw > POW_CAP) pw = POW_CAP;
    n   = (int'(tc) > N_TERMS) ? N_TERMS : int'(tc);
    acc = '0;
    for (int i = 0; i < n; i++) begin
      term = q30_mul(pw, INV_FACT[i]);
      // work on |x|, then the sign of x flips every term
      if (neg != (i % 2 == 1)) acc = acc - $signed(term);
      else acc = acc + $signed(term);
      pw = q30_mul(pw, x_sq);
    end
    rounded   = (acc + HALF_LSB) >>> DROP;
    res.angle = x;
    res.sat   = 1'b1;
    if (rounded > 64'sd32767) res.sine = 16'sh7fff;
    else if (rounded < -64'sd32768) res.sine = 16'sh8000;
    else begin
      res.sine = rounded[15:0];
      res.sat  = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    sine_expect_t want;
    if (!rst_ni) begin
      term_count_q <= sts_pkg::TERM_COUNT_RST;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      clipped_o    <= 0;
      reports      = 0;
      sine_expect_q.delete();
    end else begin
      if (cfg_we_i) term_count_q <= cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        sine_expect_q.push_back(predict_sine(angle_i, term_count_q));
      end
      if (out_valid_i && out_ready_i) begin
        checked_o <= checked_o + 1;
        if (saturated_i) clipped_o <= clipped_o + 1;
        if (sine_expect_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (reports < MAX_REPORT) begin
            $display("%0t: unexpected result sine %0d sat %0b", $time, sine_value_i,
                     saturated_i);
          end
          reports++;
        end else begin
          want = sine_expect_q.pop_front();
          if (want.sine !== sine_value_i || want.sat !== saturated_i) begin
            fail_count_o <= fail_count_o + 1;
            if (reports < MAX_REPORT) begin
              $display("%0t: angle %0d: expected sine %0d sat %0b, got sine %0d sat %0b",
                       $time, want.angle, want.sine, want.sat, sine_value_i, saturated_i);
            end
            reports++;
          end
        end
      end
      pending_o <= sine_expect_q.size();
    end
  end

endmodule

// ----- test/tb_sine_taylor_series_unit.sv -----
// Testbench top for the sine series unit: clock, reset, angle stimulus, output stalls, verdict
`timescale 1ns / 100ps

module tb_sine_taylor_series_unit;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 74;
  localparam int N_PHASES     = 10;

  // term_count per random phase: both ends, the clamped 7, and everything between
  localparam logic [sts_pkg::TC_W-1:0] PHASE_TC [N_PHASES] = '{
    3'd0, 3'd1, 3'd6, 3'd2, 3'd7, 3'd3, 3'd5, 3'd4, 3'd0, 3'd6
  };

  localparam logic signed [sts_pkg::ANGLE_W-1:0] EDGE_ANGLES [15] = '{
    16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd8192, -16'sd8192,
    16'sd12868, -16'sd12868, 16'sd25736, -16'sd25736, 16'sd16384, 16'sd21845,
    -16'sd21846, 16'sd4096
  };

  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 cfg_we_i    = 1'b0;
  logic [sts_pkg::TC_W-1:0]             cfg_wdata_i = '0;
  logic                                 in_valid_i  = 1'b0;
  logic                                 in_ready_o;
  logic signed [sts_pkg::ANGLE_W-1:0]   angle_i     = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic signed [sts_pkg::RESULT_W-1:0]  sine_value_o;
  logic                                 saturated_o;

  int   fail_count;
  int   pending;
  int   checked;
  int   clipped;
  int   angles_sent = 0;
  int   idle_cycles = 0;
  int   stall_left  = 0;
  logic tx_steady   = 1'b0;
  logic rx_steady   = 1'b0;

  sine_taylor_series_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .angle_i      (angle_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sine_value_o (sine_value_o),
    .saturated_o  (saturated_o)
  );

  sts_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .angle_i      (angle_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sine_value_i (sine_value_o),
    .saturated_i  (saturated_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .clipped_o    (clipped)
  );

  always #2 clk_i = ~clk_i;

  // receiver: ready bursts, short stalls and the odd long one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (rx_steady || $urandom_range(0, 3) != 0) begin
      out_ready_i <= 1'b1;
      stall_left  <= $urandom_range(0, 6);
    end else begin
      out_ready_i <= 1'b0;
      stall_left  <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 2);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap(input logic steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [sts_pkg::ANGLE_W-1:0] pick_angle();
    logic [15:0] mag;
    int          sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 16'($urandom);
    if (sel == 6) begin
      return $urandom_range(0, 1) ? 16'(32767 - $urandom_range(0, 15))
                                  : 16'(-32768 + $urandom_range(0, 15));
    end
    if (sel < 6) mag = 16'($urandom_range(0, 2000));
    else if (sel < 9) mag = 16'($urandom_range(0, 26000));
    else mag = 16'd1 << $urandom_range(0, 14);
    return $urandom_range(0, 1) ? 16'(-int'(mag)) : 16'(mag);
  endfunction

  task automatic push_angle(input logic signed [sts_pkg::ANGLE_W-1:0] a);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    angle_i    <= a;
    do @(posedge clk_i); while (!in_ready_o);
    angles_sent++;
  endtask

  // only written with the pipeline empty
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of term_count is six
    foreach (EDGE_ANGLES[i]) push_angle(EDGE_ANGLES[i]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= PHASE_TC[ph];
      @(posedge clk_i);
      cfg_we_i  <= 1'b0;
      tx_steady <= (ph % 3 == 2);
      rx_steady <= (ph % 4 == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) push_angle(pick_angle());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d angles over %0d term_count settings (0 through 7, 7 clamped).",
             angles_sent, N_PHASES + 1);
    $display("Checked %0d results, %0d of them clipped; %0d mismatches.",
             checked, clipped, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
